// ===== src/mzg_pkg.sv =====
package mzg_pkg;

    localparam int MaxSide   = 64;
    localparam int CoordW    = $clog2(MaxSide);
    localparam int Cells     = MaxSide * MaxSide;
    localparam int AddrW     = $clog2(Cells);
    localparam int CountW    = AddrW + 1;
    localparam int SideW     = 7;
    localparam int FlagW     = 5;
    localparam logic [31:0] LfsrTaps = 32'h8020_0003;

    localparam logic [FlagW-1:0] F_VISITED = 5'h01;
    localparam logic [FlagW-1:0] F_NORTH   = 5'h02;
    localparam logic [FlagW-1:0] F_SOUTH   = 5'h04;
    localparam logic [FlagW-1:0] F_WEST    = 5'h08;
    localparam logic [FlagW-1:0] F_EAST    = 5'h10;

    localparam logic CMD_GENERATE = 1'b0;
    localparam logic CMD_READ     = 1'b1;
    localparam logic KIND_DONE    = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic              command;
        logic [31:0]       seed;
        logic [CoordW-1:0] cell_x;
        logic [CoordW-1:0] cell_y;
    } req_t;

    typedef struct packed {
        logic result_kind;
        logic visited;
        logic door_north;
        logic door_south;
        logic door_west;
        logic door_east;
    } rsp_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_CLEAR, OP_SEED, OP_DRAW, OP_MOD_X, OP_MOD_Y, OP_START,
        OP_TOP, OP_PROBE, OP_CHOOSE, OP_CARVE_A, OP_CARVE_B, OP_CARVE_N, OP_POP, OP_READ
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] sub;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic walk_done;
        logic stack_empty;
        logic none_free;
        logic mod_done;
        logic is_read;
    } stat_t;

    function automatic logic [31:0] lfsr_step(input logic [31:0] s);
        lfsr_step = s[0] ? ((s >> 1) ^ LfsrTaps) : (s >> 1);
    endfunction

endpackage

// ===== src/mzg_ram.sv =====
module mzg_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/mzg_datapath.sv =====
module mzg_datapath
    import mzg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  req_t             req,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_idx,
    input  logic [SideW-1:0] cfg_data,
    output stat_t            stat,
    output rsp_t             rsp
);

    logic [SideW-1:0] width_reg, height_reg;
    logic [SideW-1:0] w_eff, h_eff;
    logic [31:0] rnd_reg;
    logic [39:0] rem_reg;
    logic [2:0]  mod_cnt_reg;
    logic [CountW-1:0] depth_reg, done_reg;
    logic [AddrW-1:0] clr_reg;
    logic [CoordW-1:0] cx_reg, cy_reg, sx_reg, sy_reg;
    logic [3:0] free_reg;
    logic [2:0] cnt_reg;
    logic [1:0] dir_reg;
    req_t req_reg;
    logic oob_reg;
    logic [FlagW-1:0] rd_flags_reg;

    // cell store and stack
    logic c_we;
    logic [AddrW-1:0] c_waddr, c_raddr;
    logic [FlagW-1:0] c_wdata, c_rdata;
    logic s_we;
    logic [AddrW-1:0] s_waddr, s_raddr;
    logic [AddrW-1:0] s_wdata, s_rdata;

    mzg_ram #(.Width(FlagW), .Depth(Cells)) u_cells (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata));
    mzg_ram #(.Width(AddrW), .Depth(Cells)) u_stack (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata));

    // clamp dimensions
    always_comb
    begin
        w_eff = (width_reg == '0) ? SideW'(1) :
                (width_reg > SideW'(MaxSide)) ? SideW'(MaxSide) : width_reg;
        h_eff = (height_reg == '0) ? SideW'(1) :
                (height_reg > SideW'(MaxSide)) ? SideW'(MaxSide) : height_reg;
    end

    // neighbor coordinates per direction (sub selects probe)
    logic [CoordW-1:0] nx, ny;
    logic nb_ok;
    logic [1:0] dsel;
    always_comb
    begin
        dsel = (cmd.op == OP_PROBE) ? cmd.sub[1:0] : dir_reg;
        nx = cx_reg;
        ny = cy_reg;
        nb_ok = 1'b0;
        case (dsel)
            2'd0:
            begin
                ny = cy_reg - 1'b1;
                nb_ok = (cy_reg != '0);
            end
            2'd1:
            begin
                ny = cy_reg + 1'b1;
                nb_ok = ({1'b0, cy_reg} + 7'd1) < h_eff;
            end
            2'd2:
            begin
                nx = cx_reg - 1'b1;
                nb_ok = (cx_reg != '0);
            end
            default:
            begin
                nx = cx_reg + 1'b1;
                nb_ok = ({1'b0, cx_reg} + 7'd1) < w_eff;
            end
        endcase
    end

    // remainder unit: draw mod n by restoring division, 8 bits per step
    // [39:32] partial remainder, [31:0] dividend shifting out at the top
    logic [SideW-1:0] divisor;
    logic [39:0] rem_next;
    always_comb
    begin
        case (cmd.op)
            OP_MOD_X: divisor = w_eff;
            OP_MOD_Y: divisor = h_eff;
            default:  divisor = {4'd0, cnt_reg};
        endcase
        rem_next = rem_reg;
        for (int i = 0; i < 8; i++)
        begin
            rem_next = {rem_next[38:0], 1'b0};
            if (rem_next[39:32] >= {1'b0, divisor})
            begin
                rem_next[39:32] = rem_next[39:32] - {1'b0, divisor};
            end
        end
    end

    // k-th free direction from rem
    logic [1:0] pick;
    always_comb
    begin
        pick = 2'd0;
        for (int d = 3; d >= 0; d--)
        begin
            logic [2:0] pre;
            pre = '0;
            for (int e = 0; e < d; e++)
            begin
                pre = pre + {2'b0, free_reg[e]};
            end
            if (free_reg[d] && pre == rem_reg[34:32])
            begin
                pick = 2'(d);
            end
        end
    end

    logic [FlagW-1:0] here_f, there_f;
    always_comb
    begin
        case (dir_reg)
            2'd0:
            begin
                here_f = F_NORTH;
                there_f = F_SOUTH;
            end
            2'd1:
            begin
                here_f = F_SOUTH;
                there_f = F_NORTH;
            end
            2'd2:
            begin
                here_f = F_WEST;
                there_f = F_EAST;
            end
            default:
            begin
                here_f = F_EAST;
                there_f = F_WEST;
            end
        endcase
    end

    // memory port drive
    always_comb
    begin
        c_we = 1'b0;
        c_waddr = {cy_reg, cx_reg};
        c_wdata = '0;
        c_raddr = {ny, nx};
        s_we = 1'b0;
        s_waddr = depth_reg[AddrW-1:0];
        s_wdata = {sy_reg, sx_reg};
        s_raddr = depth_reg[AddrW-1:0] - 1'b1;
        case (cmd.op)
            OP_CLEAR:
            begin
                c_we = 1'b1;
                c_waddr = clr_reg;
            end
            OP_START:
            begin
                c_we = 1'b1;
                c_waddr = {sy_reg, sx_reg};
                c_wdata = F_VISITED;
                s_we = 1'b1;
                s_waddr = '0;
            end
            OP_TOP: c_raddr = {cy_reg, cx_reg};
            OP_CARVE_A:
            begin
                c_raddr = {cy_reg, cx_reg};
            end
            OP_CARVE_B:
            begin
                c_we = 1'b1;
                c_wdata = c_rdata | F_VISITED | here_f;
                s_we = 1'b1;
            end
            // neighbor was unvisited, so its flags start from zero
            OP_CARVE_N:
            begin
                c_we = 1'b1;
                c_waddr = {sy_reg, sx_reg};
                c_wdata = F_VISITED | there_f;
            end
            OP_READ: c_raddr = {req_reg.cell_y, req_reg.cell_x};
            default: ;
        endcase
    end

    // datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= SideW'(16);
            height_reg <= SideW'(16);
            rnd_reg <= 32'd1;
            depth_reg <= '0;
            done_reg <= '0;
            clr_reg <= '0;
            mod_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == CFG_WIDTH)
                begin
                    width_reg <= cfg_data;
                end
                else
                begin
                    height_reg <= cfg_data;
                end
            end
            case (cmd.op)
                OP_LOAD: clr_reg <= '0;
                OP_CLEAR: clr_reg <= clr_reg + 1'b1;
                OP_SEED: rnd_reg <= (req_reg.seed == '0) ? 32'd1 : req_reg.seed;
                OP_DRAW:
                begin
                    rnd_reg <= lfsr_step(rnd_reg);
                    rem_reg <= {8'd0, lfsr_step(rnd_reg)};
                    mod_cnt_reg <= '0;
                end
                OP_MOD_X, OP_MOD_Y, OP_CHOOSE:
                begin
                    // four steps, then hold until the next draw
                    if (mod_cnt_reg != 3'd4)
                    begin
                        rem_reg <= rem_next;
                        mod_cnt_reg <= mod_cnt_reg + 1'b1;
                    end
                    if (mod_cnt_reg == 3'd3 && cmd.op == OP_MOD_X)
                    begin
                        sx_reg <= rem_next[CoordW+31:32];
                    end
                    if (mod_cnt_reg == 3'd3 && cmd.op == OP_MOD_Y)
                    begin
                        sy_reg <= rem_next[CoordW+31:32];
                    end
                end
                OP_START:
                begin
                    depth_reg <= CountW'(1);
                    done_reg <= CountW'(1);
                end
                OP_CARVE_A:
                begin
                    sx_reg <= nx;
                    sy_reg <= ny;
                end
                default: ;
            endcase
            if (cmd.op == OP_CARVE_B)
            begin
                depth_reg <= depth_reg + 1'b1;
                done_reg <= done_reg + 1'b1;
            end
            if (cmd.op == OP_POP)
            begin
                depth_reg <= depth_reg - 1'b1;
            end
        end
    end

    // walk registers: top fetch, probe results, choice
    logic probe_pend_reg;
    logic [1:0] probe_dir_reg;
    logic probe_ok_reg;
    logic top_pend_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_pend_reg <= 1'b0;
            top_pend_reg <= 1'b0;
        end
        else
        begin
            probe_pend_reg <= (cmd.op == OP_PROBE);
            probe_dir_reg <= cmd.sub[1:0];
            probe_ok_reg <= nb_ok;
            top_pend_reg <= (cmd.op == OP_TOP) && cmd.sub[0];
            if (probe_pend_reg)
            begin
                free_reg[probe_dir_reg] <= probe_ok_reg && !c_rdata[0];
            end
            if (cmd.op == OP_TOP && !cmd.sub[0])
            begin
                cnt_reg <= '0;
            end
            if (top_pend_reg)
            begin
                cx_reg <= s_rdata[CoordW-1:0];
                cy_reg <= s_rdata[AddrW-1:CoordW];
                free_reg <= '0;
            end
            if (cmd.op == OP_CHOOSE && cmd.sub == 3'd0)
            begin
                cnt_reg <= 3'($countones(free_reg));
            end
            if (cmd.op == OP_SEED)
            begin
                dir_reg <= '0;
            end
            if (cmd.op == OP_CHOOSE && cmd.sub == 3'd1)
            begin
                dir_reg <= pick;
            end
            if (cmd.op == OP_LOAD)
            begin
                req_reg <= req;
            end
            if (cmd.op == OP_READ)
            begin
                oob_reg <= ({1'b0, req_reg.cell_x} >= w_eff) ||
                           ({1'b0, req_reg.cell_y} >= h_eff);
            end
            // cell data is back on the second read beat; hold it for the response
            if (cmd.op == OP_READ && cmd.sub == 3'd1)
            begin
                rd_flags_reg <= oob_reg ? '0 : c_rdata;
            end
        end
    end

    always_comb
    begin
        stat.clear_done  = (clr_reg == AddrW'(Cells - 1));
        stat.walk_done   = (done_reg >= ({6'd0, w_eff} * {6'd0, h_eff}));
        stat.stack_empty = (depth_reg == '0);
        stat.none_free   = (free_reg == '0);
        stat.mod_done    = (mod_cnt_reg == 3'd4);
        stat.is_read     = (req_reg.command == CMD_READ);
        rsp.result_kind  = req_reg.command;
        rsp.visited      = rd_flags_reg[0] && stat.is_read;
        rsp.door_north   = rd_flags_reg[1] && stat.is_read;
        rsp.door_south   = rd_flags_reg[2] && stat.is_read;
        rsp.door_west    = rd_flags_reg[3] && stat.is_read;
        rsp.door_east    = rd_flags_reg[4] && stat.is_read;
    end

endmodule

// ===== src/mzg_control.sv =====
module mzg_control
    import mzg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_CLEAR, S_SEED, S_DRAW, S_MOD, S_START, S_TOP,
        S_PROBE, S_CHOOSE, S_CARVE, S_READ, S_HOLD
    } state_t;

    state_t state_reg;
    logic [2:0] sub_reg;
    logic second_reg;
    logic boot_reg;

    assign in_ready = (state_reg == S_IDLE);

    // commands follow state
    always_comb
    begin
        cmd.op = OP_NONE;
        cmd.sub = sub_reg;
        case (state_reg)
            S_IDLE: cmd.op = in_valid ? OP_LOAD : OP_NONE;
            S_CLEAR: cmd.op = OP_CLEAR;
            S_SEED: cmd.op = OP_SEED;
            S_DRAW: cmd.op = OP_DRAW;
            S_MOD: cmd.op = second_reg ? OP_MOD_Y : OP_MOD_X;
            S_START: cmd.op = OP_START;
            S_TOP: cmd.op = OP_TOP;
            S_PROBE: cmd.op = (sub_reg[2]) ? OP_NONE : OP_PROBE;
            S_CHOOSE: cmd.op = (sub_reg == 3'd2) ? OP_DRAW :
                               (sub_reg == 3'd3) ? OP_CHOOSE :
                               (sub_reg == 3'd1) ? OP_CHOOSE : OP_CHOOSE;
            S_CARVE: cmd.op = (sub_reg == 3'd0) ? OP_CARVE_A :
                              (sub_reg == 3'd1) ? OP_CARVE_B :
                              (sub_reg == 3'd2) ? OP_CARVE_N :
                              (sub_reg == 3'd4) ? OP_POP : OP_NONE;
            S_READ: cmd.op = OP_READ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // clear the cell store once after reset
            state_reg <= S_CLEAR;
            boot_reg <= 1'b1;
            sub_reg <= '0;
            second_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        state_reg <= S_DECODE;
                    end
                S_DECODE:
                    state_reg <= stat.is_read ? S_READ : S_CLEAR;
                S_CLEAR:
                    if (stat.clear_done)
                    begin
                        boot_reg <= 1'b0;
                        state_reg <= boot_reg ? S_IDLE : S_SEED;
                        second_reg <= 1'b0;
                    end
                S_SEED: state_reg <= S_DRAW;
                S_DRAW: state_reg <= S_MOD;
                S_MOD:
                    if (stat.mod_done)
                    begin
                        second_reg <= 1'b1;
                        state_reg <= second_reg ? S_START : S_DRAW;
                    end
                S_START:
                begin
                    state_reg <= S_TOP;
                    sub_reg <= '0;
                end
                S_TOP:
                begin
                    if (sub_reg == 3'd0)
                    begin
                        if (stat.walk_done || stat.stack_empty)
                        begin
                            state_reg <= S_HOLD;
                            out_valid <= 1'b1;
                        end
                        else
                        begin
                            sub_reg <= 3'd1;
                        end
                    end
                    else if (sub_reg == 3'd1)
                    begin
                        sub_reg <= 3'd2;
                    end
                    else
                    begin
                        sub_reg <= '0;
                        state_reg <= S_PROBE;
                    end
                end
                S_PROBE:
                begin
                    if (sub_reg == 3'd5)
                    begin
                        sub_reg <= '0;
                        state_reg <= S_CHOOSE;
                    end
                    else
                    begin
                        sub_reg <= sub_reg + 1'b1;
                    end
                end
                S_CHOOSE:
                begin
                    if (sub_reg == 3'd0)
                    begin
                        if (stat.none_free)
                        begin
                            state_reg <= S_CARVE;
                            sub_reg <= 3'd4;
                        end
                        else
                        begin
                            sub_reg <= 3'd2;
                        end
                    end
                    else if (sub_reg == 3'd2)
                    begin
                        sub_reg <= 3'd3;
                    end
                    else if (sub_reg == 3'd3)
                    begin
                        if (stat.mod_done)
                        begin
                            sub_reg <= 3'd1;
                        end
                    end
                    else
                    begin
                        sub_reg <= '0;
                        state_reg <= S_CARVE;
                    end
                end
                // carve: read current, write current, write neighbor; sub 4 pops
                S_CARVE:
                begin
                    if (sub_reg == 3'd4 || sub_reg == 3'd2)
                    begin
                        sub_reg <= '0;
                        state_reg <= S_TOP;
                    end
                    else
                    begin
                        sub_reg <= sub_reg + 1'b1;
                    end
                end
                S_READ:
                begin
                    if (sub_reg == 3'd1)
                    begin
                        sub_reg <= '0;
                        state_reg <= S_HOLD;
                        out_valid <= 1'b1;
                    end
                    else
                    begin
                        sub_reg <= sub_reg + 1'b1;
                    end
                end
                S_HOLD:
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/maze_generator_dfs.sv =====
// channel   | handshake                 | payload
// request   | req_valid / req_ready     | req (req_t)
// response  | rsp_valid / rsp_ready     | rsp (rsp_t)
// config    | cfg_we                    | cfg_index, cfg_data
// Reset is asynchronous, active low; a clear of all 4096 store cells follows it, requests wait.
// A read request passes the decode and read states, and its response is then registered valid.
// A generate clears the store, seeds the generator, draws the start cell, then carves
// cell by cell and backtracks through the stack, paced by the cell store (one read port,
// one write port) and the remainder unit (8 dividend bits per cycle).
// One request is in flight; the response is held until rsp_ready.
module maze_generator_dfs
    import mzg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [SideW-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;
    logic  cfg_hit;

    assign cfg_hit = cfg_we;

    mzg_control u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(req_valid), .in_ready(req_ready),
        .out_valid(rsp_valid), .out_ready(rsp_ready), .stat(stat), .cmd(cmd));

    mzg_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .req(req), .cfg_we(cfg_hit),
        .cfg_idx(cfg_index), .cfg_data(cfg_data), .stat(stat), .rsp(rsp));

    // no new request while a response waits
    assert property (@(posedge clk) disable iff (!rst_n) rsp_valid |-> !req_ready)
        else $error("request taken while response pending");
    // response holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped");

endmodule
